>>> src/matrix4_vector_transform_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix4 vector transform block
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_VECTOR_TRANSFORM_MACROS_SVH
`define MATRIX4_VECTOR_TRANSFORM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MVT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mvt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mvt: next-cycle check failed");

`endif

>>> src/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Types and constants shared by the matrix4 vector transform modules.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int NumLanes  = 4;
  localparam int NumCols   = 4;
  localparam int CoefW     = 16;
  localparam int WordW     = 32;
  localparam int ColW      = NumLanes * CoefW;
  localparam int ProdW     = CoefW + WordW;
  localparam int SumW      = ProdW + 2;
  localparam int FracShift = 12;
  localparam int CfgIdxW   = 3;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;

  localparam sum_t  RndHalf = sum_t'(2048);
  localparam word_t WordMax = word_t'(32'h7FFF_FFFF);
  localparam word_t WordMin = word_t'(32'h8000_0000);

  // Reset matrix is the identity in Q4.12.
  localparam logic [NumCols-1:0][ColW-1:0] ColReset = {
    64'h1000_0000_0000_0000,
    64'h0000_1000_0000_0000,
    64'h0000_0000_1000_0000,
    64'h0000_0000_0000_1000
  };

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLUMN0 = 3'd0,
    REG_COLUMN1 = 3'd1,
    REG_COLUMN2 = 3'd2,
    REG_COLUMN3 = 3'd3
  } cfg_reg_e;

  // Stage load strobes shared by all lanes.
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
    logic ld_rnd;
  } lane_ctl_t;

endpackage

>>> src/mvt_lane.sv
// ----------------------------------------------------------------------------
// mvt_lane
// One output row: four products, a sum, then round to Q16.16 and saturate.
// ----------------------------------------------------------------------------
module mvt_lane (
  input  logic               clk_i,
  input  mvt_pkg::lane_ctl_t ctl_i,
  input  mvt_pkg::coef_t     coef_i [mvt_pkg::NumCols],
  input  mvt_pkg::word_t     vec_i  [mvt_pkg::NumCols],
  output mvt_pkg::word_t     res_o,
  output logic               sat_o
);
  import mvt_pkg::*;

  prod_t prod_d [NumCols];
  prod_t prod_q [NumCols];
  sum_t  sum_d;
  sum_t  sum_q;
  sum_t  rounded;
  logic  in_range;
  word_t res_d;
  word_t res_q;
  logic  sat_d;
  logic  sat_q;

  always_comb begin
    for (int j = 0; j < NumCols; j++) begin
      prod_d[j] = coef_i[j] * vec_i[j];
    end
  end

  always_comb begin
    sum_d = sum_t'(prod_q[0]) + sum_t'(prod_q[1]) + sum_t'(prod_q[2]) + sum_t'(prod_q[3]);
  end

  // Round half up, then clamp when the upper bits are not a sign extension.
  always_comb begin
    rounded  = (sum_q + RndHalf) >>> FracShift;
    in_range = (&rounded[SumW-1:WordW-1]) || !(|rounded[SumW-1:WordW-1]);
    sat_d    = !in_range;
    if (in_range) begin
      res_d = rounded[WordW-1:0];
    end else if (rounded[SumW-1]) begin
      res_d = WordMin;
    end else begin
      res_d = WordMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_prod) begin
      prod_q <= prod_d;
    end
    if (ctl_i.ld_sum) begin
      sum_q <= sum_d;
    end
    if (ctl_i.ld_rnd) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

>>> src/mvt_merge.sv
// ----------------------------------------------------------------------------
// mvt_merge
// Output register: gathers the lane results and combines their clamp flags.
// ----------------------------------------------------------------------------
module mvt_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ld_i,
  input  logic                          take_i,
  input  mvt_pkg::word_t                res_i [mvt_pkg::NumLanes],
  input  logic [mvt_pkg::NumLanes-1:0]  sat_i,
  output logic                          valid_o,
  output mvt_pkg::word_t                out_x_o,
  output mvt_pkg::word_t                out_y_o,
  output mvt_pkg::word_t                out_z_o,
  output mvt_pkg::word_t                out_w_o,
  output logic                          saturated_o
);
  import mvt_pkg::*;

  logic  valid_d;
  logic  valid_q;
  word_t res_q [NumLanes];
  logic  sat_q;

  always_comb begin
    valid_d = valid_q;
    if (ld_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_i;
      sat_q <= |sat_i;
    end
  end

  assign valid_o     = valid_q;
  assign out_x_o     = res_q[0];
  assign out_y_o     = res_q[1];
  assign out_z_o     = res_q[2];
  assign out_w_o     = res_q[3];
  assign saturated_o = sat_q;

endmodule

>>> src/matrix4_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// 4x4 Q4.12 matrix times Q16.16 four-vector, rounded and saturated.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   vec_x_i vec_y_i vec_z_i vec_w_i
//   out      output     out_valid_o / out_stall_i out_x_o .. out_w_o saturated_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
// One vector per cycle while the output is not stalled; each item passes
// through the products, lane sum, round/clamp and output registers in that
// order. Reset loads the identity matrix. A stalled output holds only the
// stages behind it that are full; empty stages still fill.
// ----------------------------------------------------------------------------
`include "matrix4_vector_transform_macros.svh"

module matrix4_vector_transform (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mvt_pkg::word_t               vec_x_i,
  input  mvt_pkg::word_t               vec_y_i,
  input  mvt_pkg::word_t               vec_z_i,
  input  mvt_pkg::word_t               vec_w_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mvt_pkg::word_t               out_x_o,
  output mvt_pkg::word_t               out_y_o,
  output mvt_pkg::word_t               out_z_o,
  output mvt_pkg::word_t               out_w_o,
  output logic                         saturated_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mvt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mvt_pkg::ColW-1:0]     cfg_data_i
);
  import mvt_pkg::*;

  logic [NumCols-1:0][ColW-1:0] column_q;

  coef_t     coef [NumLanes][NumCols];
  word_t     vec  [NumCols];
  word_t     lane_res [NumLanes];
  logic [NumLanes-1:0] lane_sat;
  lane_ctl_t lane_ctl;

  logic in_xfer;
  logic out_xfer;
  logic adv1;
  logic adv2;
  logic adv3;
  logic v1_d, v1_q;
  logic v2_d, v2_q;
  logic v3_d, v3_q;

  // Configuration: always ready, unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= ColReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_COLUMN0: column_q[0] <= cfg_data_i;
        REG_COLUMN1: column_q[1] <= cfg_data_i;
        REG_COLUMN2: column_q[2] <= cfg_data_i;
        REG_COLUMN3: column_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage advances when the next one is empty or moving.
  assign out_xfer = out_valid_o && !out_stall_i;
  assign adv3     = v3_q && (!out_valid_o || !out_stall_i);
  assign adv2     = v2_q && (!v3_q || adv3);
  assign adv1     = v1_q && (!v2_q || adv2);
  assign in_stall_o = v1_q && !adv1;
  assign in_xfer  = in_valid_i && !in_stall_o;

  always_comb begin
    v1_d = in_xfer || (v1_q && !adv1);
    v2_d = adv1    || (v2_q && !adv2);
    v3_d = adv2    || (v3_q && !adv3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign lane_ctl.ld_prod = in_xfer;
  assign lane_ctl.ld_sum  = adv1;
  assign lane_ctl.ld_rnd  = adv2;

  assign vec[0] = vec_x_i;
  assign vec[1] = vec_y_i;
  assign vec[2] = vec_z_i;
  assign vec[3] = vec_w_i;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    for (genvar j = 0; j < NumCols; j++) begin : g_coef
      assign coef[i][j] = coef_t'(column_q[j][CoefW*i +: CoefW]);
    end

    mvt_lane u_lane (
      .clk_i  (clk_i),
      .ctl_i  (lane_ctl),
      .coef_i (coef[i]),
      .vec_i  (vec),
      .res_o  (lane_res[i]),
      .sat_o  (lane_sat[i])
    );
  end

  mvt_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (adv3),
    .take_i      (out_xfer),
    .res_i       (lane_res),
    .sat_i       (lane_sat),
    .valid_o     (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .saturated_o (saturated_o)
  );

  `MVT_ASSERT_SAME(a_stall_only_when_full, in_stall_o, v1_q)
  `MVT_ASSERT_NEXT(a_stage3_not_dropped, v3_q && !adv3, v3_q)
  `MVT_ASSERT_NEXT(a_bad_index_ignored, cfg_valid_i && cfg_ready_o && cfg_index_i[2], $stable(column_q))

endmodule
